[hdl/vdbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdbs_pkg
// Shared types and constants for the voxel density brush stamp.
// ----------------------------------------------------------------------------
package vdbs_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int DMAX_RAW      = 255 << FRACTION_BITS;
  localparam int DMAX_INT      = (DMAX_RAW > 65535) ? 65535 : DMAX_RAW;
  localparam logic [15:0] DENSITY_MAX = DMAX_INT[15:0];
  localparam logic [16:0] ONE_Q16     = 17'h10000;

  // Operation codes
  localparam logic [2:0] OP_SCULPT = 3'd0;
  localparam logic [2:0] OP_ERASE  = 3'd1;
  localparam logic [2:0] OP_SMOOTH = 3'd2;
  localparam logic [2:0] OP_VUNION = 3'd3;
  localparam logic [2:0] OP_VDIFF  = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_INV_RADIUS = 3'd0;
  localparam logic [2:0] REG_FALL_WIDTH = 3'd1;
  localparam logic [2:0] REG_FALL_KIND  = 3'd2;
  localparam logic [2:0] REG_BOX_SHAPE  = 3'd3;
  localparam logic [2:0] REG_STRENGTH   = 3'd4;
  localparam logic [2:0] REG_ISO_LEVEL  = 3'd5;
  localparam logic [2:0] REG_USE_CLAY   = 3'd6;
  localparam logic [2:0] REG_CLAY_GAIN  = 3'd7;

  // Falloff kinds
  localparam logic [1:0] FK_LINEAR = 2'd0;
  localparam logic [1:0] FK_SPHERE = 2'd1;
  localparam logic [1:0] FK_TIP    = 2'd2;
  localparam logic [1:0] FK_SMOOTH = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] offset_x;
    logic [15:0] offset_y;
    logic [15:0] offset_z;
    logic [15:0] old_density;
    logic [15:0] supplied_density;
    logic [15:0] plane_distance;
    logic        inside_source;
  } in_item_t;

  typedef struct packed {
    logic [15:0] new_density;
    logic        changed;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  addr;
    logic [15:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [15:0] inverse_radius;
    logic [15:0] falloff_width;
    logic [1:0]  falloff_kind;
    logic        box_shape;
    logic [15:0] base_strength;
    logic [15:0] iso_level;
    logic        use_clay;
    logic [15:0] clay_gain;
  } cfg_regs_t;

endpackage

[hdl/vdbs_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdbs_stream_if
// Valid/ready channels for items and configuration writes.
// ----------------------------------------------------------------------------
interface vdbs_in_if;
  logic valid;
  logic ready;
  vdbs_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vdbs_out_if;
  logic valid;
  logic ready;
  vdbs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vdbs_cfg_if;
  logic valid;
  logic ready;
  vdbs_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/voxel_density_brush_stamp_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_density_brush_stamp_top
// The pipe has 62 register stages (NSTG). Throughput is one item per cycle
// while the output is not stalled. Depth is set by the two pipelined
// square-root chains (one root bit per stage) and the restoring divider. A
// stall freezes the whole pipe. Reset (rst_n low, synchronous) empties the
// pipe and loads the register defaults.
// ----------------------------------------------------------------------------
module voxel_density_brush_stamp_top (
  input logic clk,
  input logic rst_n,
  vdbs_in_if.sink   in_ch,
  vdbs_cfg_if.sink  cfg_ch,
  vdbs_out_if.source out_ch
);
  import vdbs_pkg::*;

  // Stage map: 0 capture, 1 squares, 2 sum, 3..20 sqrt (18 steps of 2 bits
  // over a 36-bit radicand), 21 nd mult, 22..38 divide (17 quotient bits),
  // then falloff curve: 39 square, 40..56 sqrt, 57 curve mult, 58 weight,
  // 59 target/comb and alpha, 60 blend mult and clamp, 61 result.
  localparam int NSTG = 62;
  localparam int SQ1  = 3;
  localparam int SQN  = 18;
  localparam int DV1  = 22;
  localparam int DVN  = 17;
  localparam int SQ2  = 40;
  localparam int SQ2N = 17;

  typedef struct packed {
    in_item_t    it;
    logic        box;
    logic [17:0] ax;
    logic [17:0] ay;
    logic [17:0] az;
    logic [35:0] rem;
    logic [35:0] rad;
    logic [17:0] root;
    logic [16:0] nd;
    logic [33:0] drem;
    logic [32:0] dnum;
    logic [16:0] q;
    logic        dodiv;
    logic [16:0] weight;
    logic [33:0] srem;
    logic [33:0] srad;
    logic [16:0] sroot;
    logic [33:0] prod;
    logic [16:0] t;
    logic [16:0] comb;
    logic [16:0] alpha;
  } stg_t;

  cfg_regs_t cfg_r;
  stg_t      s_r [NSTG];
  logic [NSTG-1:0] v_r;
  logic      adv;

  assign adv          = !v_r[NSTG-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = v_r[NSTG-1];
  assign out_ch.data  = {s_r[NSTG-1].it.supplied_density, s_r[NSTG-1].it.inside_source};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{16'd256, 16'd32768, FK_SMOOTH, 1'b0, 16'd65535, 16'd32768, 1'b0,
                 16'd32768};
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.addr)
        REG_INV_RADIUS: cfg_r.inverse_radius <= cfg_ch.data.data;
        REG_FALL_WIDTH: cfg_r.falloff_width  <= cfg_ch.data.data;
        REG_FALL_KIND:  cfg_r.falloff_kind   <= cfg_ch.data.data[1:0];
        REG_BOX_SHAPE:  cfg_r.box_shape      <= cfg_ch.data.data[0];
        REG_STRENGTH:   cfg_r.base_strength  <= cfg_ch.data.data;
        REG_ISO_LEVEL:  cfg_r.iso_level      <= cfg_ch.data.data;
        REG_USE_CLAY:   cfg_r.use_clay       <= cfg_ch.data.data[0];
        REG_CLAY_GAIN:  cfg_r.clay_gain      <= cfg_ch.data.data;
        default: ;
      endcase
    end
  end

  // Valid bits advance with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], in_ch.valid};
    end
  end

  function automatic logic [17:0] abs16(input logic [15:0] v);
    logic [16:0] e;
    e = {v[15], v};
    return {1'b0, (v[15] ? (17'd0 - e) : e)};
  endfunction

  function automatic stg_t capture_fn(input in_item_t it, input cfg_regs_t c);
    stg_t s;
    s = '0;
    s.it  = it;
    s.box = c.box_shape;
    s.ax  = abs16(it.offset_x);
    s.ay  = abs16(it.offset_y);
    s.az  = abs16(it.offset_z);
    return s;
  endfunction

  function automatic stg_t stage_fn(input int k, input stg_t p, input cfg_regs_t c);
    stg_t s;
    logic [35:0] trial;
    logic [33:0] trial2;
    logic [33:0] dtry;
    logic [17:0] radial;
    logic [15:0] dsub;
    logic [16:0] fw17;
    logic [16:0] inner;
    logic [16:0] omt;
    logic [33:0] t2;
    logic signed [35:0] tgt;
    logic signed [35:0] iso;
    logic signed [35:0] dd;
    logic signed [35:0] old;
    logic signed [35:0] cb;
    logic signed [53:0] bl;
    logic signed [53:0] n;
    logic kind_vol;
    s = p;
    fw17 = {1'b0, c.falloff_width};
    inner = ONE_Q16 - fw17;
    iso = $signed({20'd0, c.iso_level});
    old = $signed({20'd0, p.it.old_density});
    kind_vol = (p.it.opcode == OP_VUNION) || (p.it.opcode == OP_VDIFF);
    trial = '0; trial2 = '0; dtry = '0; radial = '0; dsub = '0; omt = '0; t2 = '0;
    tgt = '0; dd = '0; cb = '0; bl = '0; n = '0;
    if (k == 1) begin
      s.rad = 36'(p.ax) * 36'(p.ax);
      s.rem = 36'(p.ay) * 36'(p.ay);
      s.root = p.az;
    end else if (k == 2) begin
      s.rad = p.rad + p.rem + 36'(p.root * p.root);
      s.rem = '0;
      s.root = '0;
    end else if (k >= SQ1 && k < SQ1 + SQN) begin
      // Digit-by-digit square root, two radicand bits per stage
      s.rem = {p.rem[33:0], p.rad[35:34]};
      s.rad = {p.rad[33:0], 2'b00};
      trial = 36'({p.root[16:0], 2'b01});
      if (s.rem >= trial) begin
        s.rem = s.rem - trial;
        s.root = {p.root[16:0], 1'b1};
      end else begin
        s.root = {p.root[16:0], 1'b0};
      end
    end else if (k == SQ1 + SQN) begin
      // Normalized distance
      if (p.box) begin
        radial = p.ax;
        if (p.ay > radial) radial = p.ay;
        if (p.az > radial) radial = p.az;
      end else begin
        radial = p.root;
      end
      s.prod = 34'(radial * c.inverse_radius);
      s.nd = (s.prod >> FRACTION_BITS) > 34'(ONE_Q16) ? ONE_Q16 + 17'd1 :
             17'(s.prod >> FRACTION_BITS);
      s.dodiv = (s.nd < ONE_Q16) && (s.nd > inner) && (c.falloff_width != 16'd0);
      dsub = 16'(s.nd - inner);
      // Preload the integer part so the chain yields 16 fraction bits
      s.drem = s.dodiv ? {19'd0, dsub[15:1]} : '0;
      s.dnum = s.dodiv ? {dsub[0], 32'd0} : '0;
      s.q = '0;
      if (s.nd >= ONE_Q16) s.weight = '0;
      else s.weight = ONE_Q16;
    end else if (k >= DV1 && k < DV1 + DVN) begin
      // Restoring divide of (nd - inner) << 16 by falloff_width
      s.drem = {p.drem[32:0], p.dnum[32]};
      s.dnum = {p.dnum[31:0], 1'b0};
      dtry = {18'd0, c.falloff_width};
      if (s.drem >= dtry) begin
        s.drem = s.drem - dtry;
        s.q = {p.q[15:0], 1'b1};
      end else begin
        s.q = {p.q[15:0], 1'b0};
      end
    end else if (k == DV1 + DVN) begin
      s.t = (p.q > ONE_Q16) ? ONE_Q16 : p.q;
      s.prod = 34'(s.t * s.t);
      s.srad = 34'h100000000 - s.prod;
      s.srem = '0;
      s.sroot = '0;
    end else if (k >= SQ2 && k < SQ2 + SQ2N) begin
      s.srem = {p.srem[31:0], p.srad[33:32]};
      s.srad = {p.srad[31:0], 2'b00};
      trial2 = {16'd0, p.sroot[15:0], 2'b01};
      if (s.srem >= trial2) begin
        s.srem = s.srem - trial2;
        s.sroot = {p.sroot[15:0], 1'b1};
      end else begin
        s.sroot = {p.sroot[15:0], 1'b0};
      end
    end else if (k == SQ2 + SQ2N) begin
      // Curve product
      omt = ONE_Q16 - p.t;
      case (c.falloff_kind)
        FK_TIP:    s.prod = 34'(omt * omt);
        FK_SMOOTH: s.prod = 34'(p.t * p.t);
        default:   s.prod = '0;
      endcase
    end else if (k == SQ2 + SQ2N + 1) begin
      // Finish the weight
      if (p.dodiv) begin
        omt = ONE_Q16 - p.t;
        case (c.falloff_kind)
          FK_LINEAR: s.weight = omt;
          FK_SPHERE: s.weight = p.sroot;
          FK_TIP:    s.weight = 17'(p.prod >> 16);
          default: begin
            t2 = p.prod >> 16;
            s.weight = 17'(36'(ONE_Q16) - ((36'(t2) * (36'd196608 - 36'(2 * p.t))) >> 16));
          end
        endcase
      end
      if (kind_vol) s.weight = ONE_Q16;
    end else if (k == SQ2 + SQ2N + 2) begin
      // Target and combine
      if (kind_vol || p.it.opcode == OP_SMOOTH) begin
        tgt = $signed({20'd0, p.it.supplied_density});
      end else if (c.use_clay) begin
        tgt = iso - ($signed({{20{p.it.plane_distance[15]}}, p.it.plane_distance}) *
              $signed({20'd0, c.clay_gain}) >>> 8);
      end else begin
        tgt = iso + ((($signed({20'd0, DENSITY_MAX}) - iso) *
              $signed({19'd0, ONE_Q16 - p.nd})) >>> 16);
      end
      if (p.it.opcode == OP_ERASE || p.it.opcode == OP_VDIFF) begin
        dd = (tgt >= iso) ? 2 * iso - tgt : $signed({20'd0, DENSITY_MAX});
        cb = (old < dd) ? old : dd;
      end else if (p.it.opcode == OP_SMOOTH) begin
        cb = tgt;
      end else begin
        cb = (old > tgt) ? old : tgt;
      end
      s.prod = 34'(cb);
      s.alpha = 17'((34'(c.base_strength) * 34'(p.weight)) >> 16);
    end else if (k == SQ2 + SQ2N + 3) begin
      // Blend step and clamp, pack result in the item fields
      cb = $signed({{2{p.prod[33]}}, p.prod});
      bl = (54'(cb - old) * $signed({37'd0, p.alpha}) + 54'sd32768) >>> 16;
      n = 54'(old) + bl;
      s.it.supplied_density = p.it.old_density;
      s.it.inside_source = 1'b0;
      if (p.it.opcode <= OP_VDIFF && !(kind_vol && !p.it.inside_source) &&
          p.weight != 17'd0 && n != 54'(old)) begin
        if (n < 0) n = 0;
        if (n > 54'(DENSITY_MAX)) n = 54'(DENSITY_MAX);
        s.it.supplied_density = n[15:0];
        s.it.inside_source = (n[15:0] != p.it.old_density);
      end
    end
    return s;
  endfunction

  // Datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k < NSTG; k++) begin
        s_r[k] <= stage_fn(k, s_r[k-1], cfg_r);
      end
      s_r[0] <= capture_fn(in_ch.data, cfg_r);
    end
  end

endmodule
